>>> rtl/core/tgs_pkg.sv
package tgs_pkg;

  // register stages of the locate pipeline ahead of the fraction divider
  localparam int LOC_FIXED = 14;

  // working width of the index dividers
  localparam int DW = 40;

  localparam int POS_W = 32;
  localparam int VAL_W = 32;
  localparam int LEN_W = 31;
  localparam int NC_W  = 8;
  localparam int NP_W  = 5;

  typedef logic [DW-1:0] dvec_t;

  // one restoring step: quotient bit on top, new remainder below
  function automatic logic [DW:0] div_step(input dvec_t rem, input dvec_t dsr);
    logic ge;
    ge = (rem >= dsr);
    return {ge, ge ? rem - dsr : rem};
  endfunction

endpackage

>>> rtl/core/tgs_ram.sv
module tgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tgs_locate.sv
module tgs_locate #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16,
  localparam int NL = tgs_pkg::LOC_FIXED + (FRAC_BITS + 1) / 2
) (
  input  logic                           clk,
  input  logic [NL-1:0]                  en,
  input  logic signed [tgs_pkg::POS_W-1:0] pos,
  input  logic [tgs_pkg::LEN_W-1:0]      len,
  input  logic [tgs_pkg::LEN_W-1:0]      st,
  input  logic [tgs_pkg::NC_W-1:0]       nc,
  input  logic [tgs_pkg::NP_W-1:0]       np,
  output logic [tgs_pkg::NP_W-1:0]       gid,
  output logic [FRAC_BITS:0]             w
);

  localparam int FS = (FRAC_BITS + 1) / 2;
  localparam int RW = 33;
  localparam int DW = tgs_pkg::DW;

  logic [30:0] len_e, st_e;
  logic [7:0]  nc_m1;
  logic [4:0]  np_lo, gmax;

  assign len_e = (len == '0) ? 31'd1 : len;
  assign st_e  = (st == '0) ? 31'd1 : st;
  assign nc_m1 = (nc == '0) ? 8'd0 : nc - 8'd1;
  assign np_lo = (np < 5'd2) ? 5'd2 : np;
  assign gmax  = ((7'(np_lo) > 7'(MAX_POINTS)) ? 5'(MAX_POINTS) : np_lo) - 5'd2;

  // cell index division, stages 0..5
  logic signed [31:0] p [0:6];
  tgs_pkg::dvec_t     r1 [1:4];
  logic [7:0]         q1 [1:4];
  logic               sat1 [1:4];
  logic [7:0]         id5;
  logic [38:0]        prod6;
  // grid interval division, stages 7..11
  logic signed [31:0] pp [7:11];
  tgs_pkg::dvec_t     r2 [8:9];
  logic [4:0]         q2 [8:9];
  logic               sat2 [8:9];
  logic [4:0]         g [10:NL-1];
  logic [35:0]        prod11;
  logic signed [31:0] t12;
  // weight fraction, stages 13..NL-1
  logic [RW-1:0]        r3 [13:NL-1];
  logic [FRAC_BITS-1:0] q3 [13:NL-1];
  logic                 zr [13:NL-1];
  logic                 fl [13:NL-1];

  tgs_pkg::dvec_t     r1_n [1:4];
  logic [7:0]         q1_n [1:4];
  logic               sat1_n;
  logic [7:0]         id_n;
  tgs_pkg::dvec_t     r2_n [8:9];
  logic [4:0]         q2_n [8:9];
  logic               sat2_n;
  logic [4:0]         g_n;
  logic [RW-1:0]        r3_n [14:NL-1];
  logic [FRAC_BITS-1:0] q3_n [14:NL-1];

  always_comb begin
    tgs_pkg::dvec_t       rem, rem0;
    logic [DW:0]          sr;
    logic [7:0]           qa;
    logic [4:0]           qb;
    logic [RW-1:0]        rr;
    logic [FRAC_BITS-1:0] qq;
    logic                 ge;
    int                   hb;
    int                   bi;

    // cell index: saturate at 255, then eight quotient bits
    rem0   = DW'(p[0][30:0]);
    sat1_n = (rem0 >= (DW'(len_e) << 8));
    sr     = tgs_pkg::div_step(rem0, DW'(len_e) << 7);
    r1_n[1] = sat1_n ? rem0 : sr[DW-1:0];
    q1_n[1] = sat1_n ? 8'hff : {sr[DW], 7'd0};
    for (int k = 2; k <= 4; k++) begin
      hb  = 10 - 2 * k;
      rem = r1[k-1];
      qa  = q1[k-1];
      sr  = tgs_pkg::div_step(rem, DW'(len_e) << hb);
      rem = sr[DW-1:0];
      qa[hb] = sr[DW];
      sr  = tgs_pkg::div_step(rem, DW'(len_e) << (hb - 1));
      rem = sr[DW-1:0];
      qa[hb-1] = sr[DW];
      r1_n[k] = sat1[k-1] ? r1[k-1] : rem;
      q1_n[k] = sat1[k-1] ? q1[k-1] : qa;
    end
    sr = tgs_pkg::div_step(r1[4], DW'(len_e));
    qa = sat1[4] ? q1[4] : {q1[4][7:1], sr[DW]};
    if (p[4][31]) id_n = 8'd0;
    else if (qa > nc_m1) id_n = nc_m1;
    else id_n = qa;

    // grid interval: saturate at 31, then five quotient bits
    rem0   = DW'(pp[7][30:0]);
    sat2_n = (rem0 >= (DW'(st_e) << 5));
    sr     = tgs_pkg::div_step(rem0, DW'(st_e) << 4);
    r2_n[8] = sat2_n ? rem0 : sr[DW-1:0];
    q2_n[8] = sat2_n ? 5'h1f : {sr[DW], 4'd0};
    sr  = tgs_pkg::div_step(r2[8], DW'(st_e) << 3);
    rem = sr[DW-1:0];
    qb  = q2[8];
    qb[3] = sr[DW];
    sr  = tgs_pkg::div_step(rem, DW'(st_e) << 2);
    qb[2] = sr[DW];
    r2_n[9] = sat2[8] ? r2[8] : sr[DW-1:0];
    q2_n[9] = sat2[8] ? q2[8] : qb;
    sr  = tgs_pkg::div_step(r2[9], DW'(st_e) << 1);
    rem = sr[DW-1:0];
    qb  = q2[9];
    qb[1] = sr[DW];
    sr  = tgs_pkg::div_step(rem, DW'(st_e));
    qb[0] = sr[DW];
    if (!sat2[9]) qb = qb;
    else qb = q2[9];
    if (pp[9][31]) g_n = 5'd0;
    else if (qb > gmax) g_n = gmax;
    else g_n = qb;

    // fraction bits of the weight, two per stage
    for (int s = 0; s < FS; s++) begin
      rr = r3[13+s];
      qq = q3[13+s];
      for (int n = 0; n < 2; n++) begin
        if (2 * s + n < FRAC_BITS) begin
          bi = FRAC_BITS - 1 - (2 * s + n);
          rr = rr << 1;
          ge = (rr >= RW'(st_e));
          if (ge) rr = rr - RW'(st_e);
          qq[bi] = ge;
        end
      end
      r3_n[14+s] = rr;
      q3_n[14+s] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) p[0] <= pos;
    for (int s = 1; s <= 6; s++) begin
      if (en[s]) p[s] <= p[s-1];
    end
    for (int k = 1; k <= 4; k++) begin
      if (en[k]) begin
        r1[k] <= r1_n[k];
        q1[k] <= q1_n[k];
      end
    end
    if (en[1]) sat1[1] <= sat1_n;
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) sat1[k] <= sat1[k-1];
    end
    if (en[5]) id5 <= id_n;
    if (en[6]) prod6 <= 39'(id5) * 39'(len_e);
    if (en[7]) pp[7] <= p[6] - 32'(prod6);
    for (int s = 8; s <= 11; s++) begin
      if (en[s]) pp[s] <= pp[s-1];
    end
    for (int k = 8; k <= 9; k++) begin
      if (en[k]) begin
        r2[k] <= r2_n[k];
        q2[k] <= q2_n[k];
      end
    end
    if (en[8]) sat2[8] <= sat2_n;
    if (en[9]) sat2[9] <= sat2[8];
    if (en[10]) g[10] <= g_n;
    for (int s = 11; s < NL; s++) begin
      if (en[s]) g[s] <= g[s-1];
    end
    if (en[11]) prod11 <= 36'(g[10]) * 36'(st_e);
    if (en[12]) t12 <= pp[11] - 32'(prod11);
    if (en[13]) begin
      zr[13] <= t12[31];
      fl[13] <= !t12[31] && (t12[30:0] >= st_e);
      r3[13] <= RW'(t12[30:0]);
      q3[13] <= '0;
    end
    for (int s = 14; s < NL; s++) begin
      if (en[s]) begin
        zr[s] <= zr[s-1];
        fl[s] <= fl[s-1];
        r3[s] <= r3_n[s];
        q3[s] <= q3_n[s];
      end
    end
  end

  assign gid = g[NL-1];
  assign w   = zr[NL-1] ? '0 : (fl[NL-1] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q3[NL-1]});

endmodule

>>> rtl/core/tgs_lerp.sv
module tgs_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en1,
  input  logic               en2,
  input  logic signed [31:0] v0,
  input  logic signed [31:0] v1,
  input  logic [FRAC_BITS:0] w,
  output logic signed [31:0] y
);

  localparam int WW = FRAC_BITS + 1;
  localparam int PW = 33 + WW + 1;
  localparam logic signed [PW:0] HALF = (PW + 1)'(1) <<< (FRAC_BITS - 1);

  logic signed [32:0]   diff;
  logic signed [PW-1:0] prod_n, prod_q;
  logic signed [31:0]   v0_q;
  logic signed [PW:0]   sum;

  // v0*(1-w) + v1*w folded into one product
  always_comb begin
    diff   = 33'(v1) - 33'(v0);
    prod_n = PW'(diff) * PW'($signed({1'b0, w}));
  end

  // round half up, then floor shift
  assign sum = ((PW + 1)'(v0_q) <<< FRAC_BITS) + (PW + 1)'(prod_q) + HALF;

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_q <= prod_n;
      v0_q   <= v0;
    end
    if (en2) y <= 32'(sum >>> FRAC_BITS);
  end

endmodule

>>> rtl/core/trilinear_grid_sampler.sv
// channel   direction  fields                                       handshake
// in        input      mode pos_x pos_y pos_z grid_i grid_j grid_k  in_valid / in_stall
//                      point_value
// out       output     sample_value                                 out_valid / out_stall
// config    input      apb write/read, registers at 4*i             psel penable pwrite pready
//
// one request enters per cycle while in_stall is low; a query's sample passes in order through
// the two index dividers, the two-bits-a-stage weight divider, the banked read and three lerp
// stages, each with a product and a result register. writes give no sample and update the
// grid as they pass the memory stage, so later queries see them in order.
// synchronous reset clears the valid bits and loads the register defaults; the grid holds
// whatever was last written. a stalled stage holds, and empty stages ahead of it still fill.
module trilinear_grid_sampler #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [3:0]         grid_i,
  input  logic [3:0]         grid_j,
  input  logic [3:0]         grid_k,
  input  logic signed [31:0] point_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NL   = tgs_pkg::LOC_FIXED + (FRAC_BITS + 1) / 2;
  localparam int NS   = NL + 8;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int HW   = (IW > 1) ? IW - 1 : 1;
  localparam int HALF = (MAX_POINTS + 1) / 2;
  localparam int BD   = HALF * HALF * HALF;
  localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
  localparam int WW   = FRAC_BITS + 1;

  localparam logic [2:0] REG_CELL_LEN_X = 3'd0;
  localparam logic [2:0] REG_CELL_LEN_Y = 3'd1;
  localparam logic [2:0] REG_CELL_LEN_Z = 3'd2;
  localparam logic [2:0] REG_STEP_X     = 3'd3;
  localparam logic [2:0] REG_STEP_Y     = 3'd4;
  localparam logic [2:0] REG_STEP_Z     = 3'd5;
  localparam logic [2:0] REG_CELLS      = 3'd6;
  localparam logic [2:0] REG_POINTS     = 3'd7;

  // configuration
  logic [30:0] cell_len_x, cell_len_y, cell_len_z, step_x, step_y, step_z;
  logic [23:0] cell_counts;
  logic [14:0] points_per_axis;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_len_x      <= 31'd65536;
      cell_len_y      <= 31'd65536;
      cell_len_z      <= 31'd65536;
      step_x          <= 31'd4369;
      step_y          <= 31'd4369;
      step_z          <= 31'd4369;
      cell_counts     <= 24'd65793;
      points_per_axis <= 15'd16912;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_CELL_LEN_X: cell_len_x      <= pwdata[30:0];
        REG_CELL_LEN_Y: cell_len_y      <= pwdata[30:0];
        REG_CELL_LEN_Z: cell_len_z      <= pwdata[30:0];
        REG_STEP_X:     step_x          <= pwdata[30:0];
        REG_STEP_Y:     step_y          <= pwdata[30:0];
        REG_STEP_Z:     step_z          <= pwdata[30:0];
        REG_CELLS:      cell_counts     <= pwdata[23:0];
        REG_POINTS:     points_per_axis <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CELL_LEN_X: prdata = 32'(cell_len_x);
      REG_CELL_LEN_Y: prdata = 32'(cell_len_y);
      REG_CELL_LEN_Z: prdata = 32'(cell_len_z);
      REG_STEP_X:     prdata = 32'(step_x);
      REG_STEP_Y:     prdata = 32'(step_y);
      REG_STEP_Z:     prdata = 32'(step_z);
      REG_CELLS:      prdata = 32'(cell_counts);
      REG_POINTS:     prdata = 32'(points_per_axis);
      default:        prdata = '0;
    endcase
  end

  // stage valids and load enables
  logic [NS-1:0] v, en;

  always_comb begin
    en[NS-1] = !v[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NS-1];

  logic is_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) begin
          if (s == 0) v[s] <= in_valid;
          else if (s == NL + 1) v[s] <= v[s-1] && is_q;
          else v[s] <= v[s-1];
        end
      end
    end
  end

  // request fields riding alongside the locate pipeline
  logic        md_mode [0:NL-1];
  logic [3:0]  md_i [0:NL-1];
  logic [3:0]  md_j [0:NL-1];
  logic [3:0]  md_k [0:NL-1];
  logic [31:0] md_val [0:NL-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      md_mode[0] <= mode;
      md_i[0]    <= grid_i;
      md_j[0]    <= grid_j;
      md_k[0]    <= grid_k;
      md_val[0]  <= point_value;
    end
    for (int s = 1; s < NL; s++) begin
      if (en[s]) begin
        md_mode[s] <= md_mode[s-1];
        md_i[s]    <= md_i[s-1];
        md_j[s]    <= md_j[s-1];
        md_k[s]    <= md_k[s-1];
        md_val[s]  <= md_val[s-1];
      end
    end
  end

  logic [4:0]    loc_gx, loc_gy, loc_gz;
  logic [WW-1:0] loc_wx, loc_wy, loc_wz;

  tgs_locate #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_loc_x (
    .clk(clk), .en(en[NL-1:0]), .pos(pos_x), .len(cell_len_x), .st(step_x),
    .nc(cell_counts[7:0]), .np(points_per_axis[4:0]), .gid(loc_gx), .w(loc_wx)
  );

  tgs_locate #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_loc_y (
    .clk(clk), .en(en[NL-1:0]), .pos(pos_y), .len(cell_len_y), .st(step_y),
    .nc(cell_counts[15:8]), .np(points_per_axis[9:5]), .gid(loc_gy), .w(loc_wy)
  );

  tgs_locate #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_loc_z (
    .clk(clk), .en(en[NL-1:0]), .pos(pos_z), .len(cell_len_z), .st(step_z),
    .nc(cell_counts[23:16]), .np(points_per_axis[14:10]), .gid(loc_gz), .w(loc_wz)
  );

  // bank addressing: bank {x,y,z parity} holds exactly one of the eight corners
  logic [IW-1:0] gx, gy, gz, wi, wj, wk;
  logic [AW-1:0] rd_addr_n [8];
  logic [AW-1:0] rd_addr [8];
  logic [AW-1:0] wr_addr_n, wr_addr;
  logic [2:0]    wr_bank;
  logic          wr_ok;
  logic [31:0]   wr_data;
  logic [2:0]    par_q [0:1];
  logic [WW-1:0] wx_q [0:1];
  logic [WW-1:0] wy_q [0:3];
  logic [WW-1:0] wz_q [0:5];

  assign gx = IW'(loc_gx);
  assign gy = IW'(loc_gy);
  assign gz = IW'(loc_gz);
  assign wi = IW'(md_i[NL-1]);
  assign wj = IW'(md_j[NL-1]);
  assign wk = IW'(md_k[NL-1]);

  always_comb begin
    logic [IW-1:0] cx, cy, cz;
    logic [HW-1:0] hx, hy, hz;
    for (int b = 0; b < 8; b++) begin
      cx = (gx[0] == 1'((b >> 2) & 1)) ? gx : gx + IW'(1);
      cy = (gy[0] == 1'((b >> 1) & 1)) ? gy : gy + IW'(1);
      cz = (gz[0] == 1'(b & 1)) ? gz : gz + IW'(1);
      hx = HW'(cx >> 1);
      hy = HW'(cy >> 1);
      hz = HW'(cz >> 1);
      rd_addr_n[b] = AW'((int'(hx) * HALF + int'(hy)) * HALF + int'(hz));
    end
    hx = HW'(wi >> 1);
    hy = HW'(wj >> 1);
    hz = HW'(wk >> 1);
    wr_addr_n = AW'((int'(hx) * HALF + int'(hy)) * HALF + int'(hz));
  end

  always_ff @(posedge clk) begin
    if (en[NL]) begin
      is_q     <= md_mode[NL-1];
      wr_ok    <= (32'(md_i[NL-1]) < MAX_POINTS) && (32'(md_j[NL-1]) < MAX_POINTS)
                  && (32'(md_k[NL-1]) < MAX_POINTS);
      wr_bank  <= {wi[0], wj[0], wk[0]};
      wr_addr  <= wr_addr_n;
      wr_data  <= md_val[NL-1];
      rd_addr  <= rd_addr_n;
      par_q[0] <= {gx[0], gy[0], gz[0]};
      wx_q[0]  <= loc_wx;
      wy_q[0]  <= loc_wy;
      wz_q[0]  <= loc_wz;
    end
    if (en[NL+1]) begin
      par_q[1] <= par_q[0];
      wx_q[1]  <= wx_q[0];
    end
    for (int s = 1; s < 4; s++) begin
      if (en[NL+s]) wy_q[s] <= wy_q[s-1];
    end
    for (int s = 1; s < 6; s++) begin
      if (en[NL+s]) wz_q[s] <= wz_q[s-1];
    end
  end

  logic [31:0] rd [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    tgs_ram #(.WIDTH(tgs_pkg::VAL_W), .DEPTH(BD)) u_ram (
      .clk(clk),
      .we(en[NL+1] && v[NL] && !is_q && wr_ok && (wr_bank == 3'(b))),
      .waddr(wr_addr),
      .wdata(wr_data),
      .re(en[NL+1]),
      .raddr(rd_addr[b]),
      .rdata(rd[b])
    );
  end

  // corner (a,b,c) sits in bank {a,b,c} xor the low bits of the interval
  logic signed [31:0] xv0 [4];
  logic signed [31:0] xv1 [4];
  logic signed [31:0] xc [4];
  logic signed [31:0] yd [2];

  always_comb begin
    logic [2:0] lo;
    for (int bc = 0; bc < 4; bc++) begin
      lo = {1'b0, 1'((bc >> 1) & 1), 1'(bc & 1)};
      xv0[bc] = $signed(rd[par_q[1] ^ lo]);
      xv1[bc] = $signed(rd[par_q[1] ^ lo ^ 3'b100]);
    end
  end

  for (genvar bc = 0; bc < 4; bc++) begin : g_lx
    tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk(clk), .en1(en[NL+2]), .en2(en[NL+3]),
      .v0(xv0[bc]), .v1(xv1[bc]), .w(wx_q[1]), .y(xc[bc])
    );
  end

  for (genvar c = 0; c < 2; c++) begin : g_ly
    tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk(clk), .en1(en[NL+4]), .en2(en[NL+5]),
      .v0(xc[c]), .v1(xc[2+c]), .w(wy_q[3]), .y(yd[c])
    );
  end

  // the result always lies between its corner values, so no clamp is needed
  tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
    .clk(clk), .en1(en[NL+6]), .en2(en[NL+7]),
    .v0(yd[0]), .v1(yd[1]), .w(wz_q[5]), .y(sample_value)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&v) && out_stall))
    else $error("input stalled with a free stage");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    v[NL-1] |-> ((loc_wx <= (WW'(1) << FRAC_BITS)) && (loc_wy <= (WW'(1) << FRAC_BITS))
                 && (loc_wz <= (WW'(1) << FRAC_BITS))))
    else $error("weight above one");

  a_gid_range: assert property (@(posedge clk) disable iff (rst)
    (v[NL-1] && md_mode[NL-1]) |-> ((32'(loc_gx) <= MAX_POINTS - 2)
                 && (32'(loc_gy) <= MAX_POINTS - 2) && (32'(loc_gz) <= MAX_POINTS - 2)))
    else $error("grid interval beyond last full interval");

  a_write_drop: assert property (@(posedge clk) disable iff (rst)
    (en[NL+1] && v[NL] && !is_q) |=> !v[NL+1])
    else $error("write request reached the lerp stages");

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NPTS      = 16;
  localparam int  FRAC      = 16;
  localparam longint ONE_W  = longint'(1) << FRAC;
  localparam int  LATENCY   = 30;
  localparam longint LIMIT  = 600000;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [4:0] REG_CELL_LEN_X = 5'd0;
  localparam logic [4:0] REG_CELL_LEN_Y = 5'd4;
  localparam logic [4:0] REG_CELL_LEN_Z = 5'd8;
  localparam logic [4:0] REG_STEP_X     = 5'd12;
  localparam logic [4:0] REG_STEP_Y     = 5'd16;
  localparam logic [4:0] REG_STEP_Z     = 5'd20;
  localparam logic [4:0] REG_CELLS      = 5'd24;
  localparam logic [4:0] REG_POINTS     = 5'd28;

  typedef struct {
    logic               mode;
    logic signed [31:0] px, py, pz;
    logic [3:0]         gi, gj, gk;
    logic signed [31:0] val;
  } grid_req_t;

  logic clk, rst;
  logic in_valid, in_stall, mode;
  logic signed [31:0] pos_x, pos_y, pos_z, point_value;
  logic [3:0] grid_i, grid_j, grid_k;
  logic out_valid, out_stall;
  logic signed [31:0] sample_value;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  trilinear_grid_sampler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .grid_i(grid_i), .grid_j(grid_j), .grid_k(grid_k), .point_value(point_value),
    .out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block's registers and grid
  longint cfg_len [3];
  longint cfg_step[3];
  logic [23:0] cfg_cells;
  logic [14:0] cfg_points;
  logic signed [31:0] grid_mem[NPTS*NPTS*NPTS];
  bit point_written[NPTS*NPTS*NPTS];

  grid_req_t pending_reqs[$];
  logic signed [31:0] expected_samples[$];
  int  errors = 0;
  int  n_queries = 0, n_writes = 0, n_samples = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic void locate(input int axis, input longint pos,
                                 output longint gid, output longint w);
    longint len, st, nc, np, id, g, t;
    len = cfg_len[axis];
    st  = cfg_step[axis];
    nc  = (cfg_cells >> (8*axis)) & 8'hFF;
    np  = (cfg_points >> (5*axis)) & 5'h1F;
    if (len == 0) len = 1;
    if (st == 0) st = 1;
    if (nc == 0) nc = 1;
    if (np < 2) np = 2;
    if (np > NPTS) np = NPTS;
    id = floor_quot(pos, len);
    if (id < 0) id = 0;
    else if (id > nc - 1) id = nc - 1;
    pos = pos - id * len;
    g = floor_quot(pos, st);
    if (g < 0) g = 0;
    else if (g > np - 2) g = np - 2;
    t = pos - g * st;
    if (t < 0) w = 0;
    else if (t >= st) w = ONE_W;
    else w = (t << FRAC) / st;
    gid = g;
  endfunction

  function automatic int point_slot(longint i, longint j, longint k);
    return int'((i * NPTS + j) * NPTS + k);
  endfunction

  function automatic longint blend(longint v0, longint v1, longint w);
    return (v0 * (ONE_W - w) + v1 * w + (ONE_W >>> 1)) >>> FRAC;
  endfunction

  // applies an accepted write to the shadow grid, or gives the sample an accepted query owes
  function automatic bit sample_of(input grid_req_t r, output logic signed [31:0] s);
    longint g[3], w[3], c[2][2], d[2], acc;
    if (r.mode == MODE_WRITE) begin
      grid_mem[point_slot(r.gi, r.gj, r.gk)] = r.val;
      return 0;
    end
    locate(0, longint'(r.px), g[0], w[0]);
    locate(1, longint'(r.py), g[1], w[1]);
    locate(2, longint'(r.pz), g[2], w[2]);
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        c[a][b] = blend(longint'(grid_mem[point_slot(g[0], g[1]+a, g[2]+b)]),
                        longint'(grid_mem[point_slot(g[0]+1, g[1]+a, g[2]+b)]), w[0]);
    for (int b = 0; b < 2; b++) d[b] = blend(c[0][b], c[1][b], w[1]);
    acc = blend(d[0], d[1], w[2]);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    s = acc[31:0];
    return 1;
  endfunction

  // driver: bursts with random gaps, plus a hold-off from the sequence
  int  burst_left = 4, gap_left = 0;
  bit  hold_off = 0;
  always @(posedge clk) begin
    grid_req_t r;
    logic signed [31:0] s;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        r.mode = mode; r.px = pos_x; r.py = pos_y; r.pz = pos_z;
        r.gi = grid_i; r.gj = grid_j; r.gk = grid_k; r.val = point_value;
        if (sample_of(r, s)) expected_samples.push_back(s);
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 0;
      end else if (!hold_off && pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        mode <= r.mode; pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz;
        grid_i <= r.gi; grid_j <= r.gj; grid_k <= r.gk; point_value <= r.val;
        in_valid <= 1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall pattern, chosen at random from four styles
  int stall_style = 0, stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 256 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (stall_cnt % 7) < 3;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      n_samples <= n_samples + 1;
      if (expected_samples.size() == 0) begin
        $error("sample_value with no query waiting: got %0d", sample_value);
        errors <= errors + 1;
      end else begin
        want = expected_samples.pop_front();
        if (sample_value !== want) begin
          $error("sample_value mismatch: expected %0d actual %0d", want, sample_value);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_registers(input logic [31:0] len[3], input logic [31:0] st[3],
                               input logic [31:0] cells, input logic [31:0] pts);
    reg_write(REG_CELL_LEN_X, len[0]);
    reg_write(REG_CELL_LEN_Y, len[1]);
    reg_write(REG_CELL_LEN_Z, len[2]);
    reg_write(REG_STEP_X, st[0]);
    reg_write(REG_STEP_Y, st[1]);
    reg_write(REG_STEP_Z, st[2]);
    reg_write(REG_CELLS, cells);
    reg_write(REG_POINTS, pts);
    for (int a = 0; a < 3; a++) begin
      cfg_len[a]  = len[a] & 32'h7FFF_FFFF;
      cfg_step[a] = st[a] & 32'h7FFF_FFFF;
    end
    cfg_cells  = cells[23:0];
    cfg_points = pts[14:0];
  endtask

  // checked on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_samples.size() > 0)
      @(negedge clk);
  endtask

  task automatic push_write(input int i, input int j, input int k,
                            input logic signed [31:0] v);
    grid_req_t r;
    r.mode = MODE_WRITE; r.gi = 4'(i); r.gj = 4'(j); r.gk = 4'(k); r.val = v;
    r.px = $urandom; r.py = $urandom; r.pz = $urandom;
    point_written[point_slot(i, j, k)] = 1;
    pending_reqs.push_back(r);
    n_writes++;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  // corners a query will read that were never written get written first
  task automatic push_query(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    grid_req_t r;
    longint g[3], w;
    locate(0, longint'(x), g[0], w);
    locate(1, longint'(y), g[1], w);
    locate(2, longint'(z), g[2], w);
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++)
          if (!point_written[point_slot(g[0]+a, g[1]+b, g[2]+c)])
            push_write(int'(g[0]+a), int'(g[1]+b), int'(g[2]+c), rand_value());
    r.mode = MODE_QUERY; r.px = x; r.py = y; r.pz = z;
    r.gi = 4'($urandom); r.gj = 4'($urandom); r.gk = 4'($urandom); r.val = $urandom;
    pending_reqs.push_back(r);
    n_queries++;
  endtask

  function automatic logic signed [31:0] rand_pos(input int axis);
    longint st, span, p;
    longint unsigned u;
    st = (cfg_step[axis] == 0) ? 1 : cfg_step[axis];
    span = ((cfg_len[axis] == 0) ? 1 : cfg_len[axis]) *
           ((((cfg_cells >> (8*axis)) & 8'hFF) == 0) ? 1 : ((cfg_cells >> (8*axis)) & 8'hFF));
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: begin
        u = {$urandom, $urandom};
        p = longint'(u % longint'(span + 2*st)) - st;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
      end
    endcase
  endfunction

  initial begin
    logic [31:0] len[3], st[3], cells, pts;
    int ncfg;
    rst = 1; in_valid = 0; mode = 0; pos_x = 0; pos_y = 0; pos_z = 0;
    grid_i = 0; grid_j = 0; grid_k = 0; point_value = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    for (int a = 0; a < 3; a++) begin
      cfg_len[a] = 65536; cfg_step[a] = 4369;
    end
    cfg_cells = 24'h010101; cfg_points = 15'd16912;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extreme grid addresses and values, extreme positions, default registers
    push_write(0, 0, 0, 32'sh7FFF_FFFF);
    push_write(15, 15, 15, 32'sh8000_0000);
    push_write(15, 0, 15, 32'sh0000_0000);
    push_write(0, 15, 0, -32'sd1);
    push_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_query(0, 0, 0);
    push_query(32'sh0000_1111, 32'sh0000_0888, 32'sh0000_FFFF);
    push_query(32'sh0001_0000, -32'sd1, 32'sh0000_8000);
    drain();

    ncfg = 9;
    for (int ph = 0; ph < ncfg; ph++) begin
      repeat (LATENCY + 10) @(posedge clk);
      case (ph)
        0: begin
          len = '{32'h0003_0000, 32'h0002_0000, 32'h0001_8000};
          st  = '{32'h0000_8000, 32'h0000_4000, 32'h0000_2000};
          cells = 32'h0003_0201; pts = (5 << 10) | (4 << 5) | 3;
        end
        1: begin
          len = '{32'd1, 32'd1, 32'd1}; st = '{32'd1, 32'd1, 32'd1};
          cells = 0; pts = 0;
        end
        2: begin
          len = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
          st  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
          cells = 32'hFFFF_FFFF; pts = 32'hFFFF_FFFF;
        end
        3: begin
          // zero lengths and steps, top bit dropped by the 31-bit registers
          len = '{32'h8000_0000, 32'd0, 32'h8000_0000};
          st  = '{32'd0, 32'h8000_0000, 32'd0};
          cells = 32'h00FF_00FF; pts = (1 << 10) | (31 << 5) | 17;
        end
        4: begin
          len = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
          st  = '{32'd4369, 32'd4369, 32'd4369};
          cells = 32'h0001_0101; pts = 32'd16912;
        end
        default: begin
          for (int a = 0; a < 3; a++) begin
            len[a] = $urandom_range(32'h0000_1000, 32'h0010_0000);
            st[a]  = len[a] / $urandom_range(1, 16) + $urandom_range(0, 3);
          end
          cells = {7'd0, 1'($urandom_range(0, 1)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(1, 8)), 8'($urandom_range(1, 8))};
          pts = ($urandom_range(2, 16) << 10) | ($urandom_range(2, 16) << 5)
                | $urandom_range(2, 16);
        end
      endcase
      set_registers(len, st, cells, pts);

      for (int n = 0; n < 150; n++) begin
        if (n == 75) begin
          hold_off = 1;
          drain_wait();
          hold_off = 0;
        end
        if ($urandom_range(0, 9) < 3)
          push_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                     rand_value());
        else
          push_query(rand_pos(0), rand_pos(1), rand_pos(2));
        while (pending_reqs.size() > 64) @(posedge clk);
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d queries and %0d grid writes over %0d register settings",
             n_queries, n_writes, ncfg + 1);
    $display("%0d samples checked, %0d mismatches", n_samples, errors);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // pause with the sender held off until every owed sample has come back
  task automatic drain_wait();
    while (in_valid || expected_samples.size() > 0) @(negedge clk);
  endtask

endmodule

>>> trilinear_grid_sampler.f
rtl/core/tgs_pkg.sv
rtl/core/tgs_ram.sv
rtl/core/tgs_locate.sv
rtl/core/tgs_lerp.sv
rtl/core/trilinear_grid_sampler.sv
dv/tb.sv
